### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication into the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  `ASSERT_CLK(lbl, clk, rstn, (pre) |=> (post), msg)

`endif

### hw/rtl/pscol_pkg.sv
`timescale 1ns / 1ps
package pscol_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned DivNumW     = 64;
  localparam int unsigned DivDenW     = 32;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               vertex_present;
    logic               finish;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_AX_START,
    BK_AX_RD1,
    BK_AX_RD2,
    BK_AX_CALC,
    BK_NORM,
    BK_SQ1,
    BK_SQ2,
    BK_SQ3,
    BK_SQRT,
    BK_DIVX_GO,
    BK_DIVX_WAIT,
    BK_DIVY_GO,
    BK_DIVY_WAIT,
    BK_PJ_RD,
    BK_PJ_MX,
    BK_PJ_MY,
    BK_PJ_AC,
    BK_OV,
    BK_CS_RD,
    BK_CS_AC,
    BK_CD_GO,
    BK_CD_WAIT,
    BK_CHOOSE,
    BK_DOT1,
    BK_DOT2,
    BK_DOT3,
    BK_PU_LO,
    BK_PU_HI,
    BK_PU_FIN,
    BK_EMIT_HIT,
    BK_EMIT_MISS
  } back_state_e;

endpackage

### hw/rtl/pscol_ram.sv
`timescale 1ns / 1ps
module pscol_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pscol_div.sv
`timescale 1ns / 1ps
module pscol_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pscol_pkg::div_req_t req_i,
  output pscol_pkg::div_rsp_t rsp_o
);
  import pscol_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivNumW-1:0] quot_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   shifted;
  logic               ge;
  logic [DivDenW:0]   diff;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quot_q[DivNumW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.num;
      den_q  <= req_i.den;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[DivNumW-2:0], ge};
      rem_q  <= ge ? diff[DivDenW-1:0] : shifted[DivDenW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### hw/rtl/pscol_front.sv
`timescale 1ns / 1ps
module pscol_front #(
  parameter int unsigned MAX_VERTICES = pscol_pkg::MaxVertices
) (
  input  logic                                                       clk_i,
  input  logic                                                       rst_ni,
  input  logic                                                       start,
  input  pscol_pkg::in_t                                             in_i,
  output logic                                                       busy,
  input  logic                                                       back_busy_i,
  output logic                                                       we_a_o,
  output logic                                                       we_b_o,
  output logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] waddr_o,
  output logic [63:0]                                                wdata_o,
  output logic                                                       job_valid_o,
  output logic [$clog2(MAX_VERTICES + 1)-1:0]                        job_na_o,
  output logic [$clog2(MAX_VERTICES + 1)-1:0]                        job_nb_o,
  input  logic                                                       job_pop_i
);
  import pscol_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic            accept;
  logic            room_a;
  logic            room_b;
  logic [CntW-1:0] cnt_a_q, cnt_a_d;
  logic [CntW-1:0] cnt_b_q, cnt_b_d;
  logic [CntW-1:0] na_new;
  logic [CntW-1:0] nb_new;
  logic            push;

  // two-entry job queue toward the back end
  logic [CntW-1:0] ent_na_q [2];
  logic [CntW-1:0] ent_nb_q [2];
  logic            wp_q, wp_d;
  logic            rp_q, rp_d;
  logic [1:0]      lvl_q, lvl_d;

  assign accept = start && !busy;
  assign busy   = (lvl_q != 2'd0) || back_busy_i;
  assign room_a = cnt_a_q < CntW'(MAX_VERTICES);
  assign room_b = cnt_b_q < CntW'(MAX_VERTICES);

  assign we_a_o  = accept && in_i.vertex_present && !in_i.mode && room_a;
  assign we_b_o  = accept && in_i.vertex_present && in_i.mode && room_b;
  assign waddr_o = in_i.mode ? cnt_b_q[AddrW-1:0] : cnt_a_q[AddrW-1:0];
  assign wdata_o = {in_i.coord_x, in_i.coord_y};

  assign na_new = we_a_o ? cnt_a_q + 1'b1 : cnt_a_q;
  assign nb_new = we_b_o ? cnt_b_q + 1'b1 : cnt_b_q;
  assign push   = accept && in_i.finish;

  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    if (accept) begin
      cnt_a_d = in_i.finish ? '0 : na_new;
      cnt_b_d = in_i.finish ? '0 : nb_new;
    end
    wp_d  = push ? !wp_q : wp_q;
    rp_d  = job_pop_i ? !rp_q : rp_q;
    lvl_d = lvl_q + {1'b0, push} - {1'b0, job_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      lvl_q   <= 2'd0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      lvl_q   <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_na_q[wp_q] <= na_new;
      ent_nb_q[wp_q] <= nb_new;
    end
  end

  assign job_valid_o = lvl_q != 2'd0;
  assign job_na_o    = ent_na_q[rp_q];
  assign job_nb_o    = ent_nb_q[rp_q];

endmodule

### hw/rtl/pscol_back.sv
`timescale 1ns / 1ps
module pscol_back #(
  parameter int unsigned MAX_VERTICES = pscol_pkg::MaxVertices
) (
  input  logic                                                       clk_i,
  input  logic                                                       rst_ni,
  input  logic                                                       job_valid_i,
  input  logic [$clog2(MAX_VERTICES + 1)-1:0]                        job_na_i,
  input  logic [$clog2(MAX_VERTICES + 1)-1:0]                        job_nb_i,
  output logic                                                       job_pop_o,
  input  logic [63:0]                                                a_rdata_i,
  input  logic [63:0]                                                b_rdata_i,
  output logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] raddr_o,
  output pscol_pkg::div_req_t                                        div_req_o,
  input  pscol_pkg::div_rsp_t                                        div_rsp_i,
  output logic                                                       busy_o,
  output logic                                                       done_o,
  output pscol_pkg::res_t                                            res_o
);
  import pscol_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned SumW  = CoordW + CntW;

  back_state_e state_q, state_d;

  // control
  logic [CntW-1:0] na_q, nb_q;
  logic            pass_q, side_q;
  logic [CntW-1:0] ax_i_q, k_q;
  logic [1:0]      cd_q;
  logic            comp_q;
  logic            done_q;
  res_t            res_q;

  // edge axis
  logic signed [31:0] xi_q, yi_q;
  logic               nxneg_q, nyneg_q;
  logic [32:0]        mx_q, my_q;
  logic [61:0]        sq1_q, sq2_q;
  logic [63:0]        x_q, r_q, bit_q;
  logic signed [31:0] ux_q, uy_q;

  // projection and overlap
  logic signed [63:0] prodx_q, prody_q;
  logic signed [31:0] yl_q;
  logic signed [47:0] lo_q, hi_q, plo_q, phi_q;
  logic signed [48:0] best_q, oa_q, ob_q;
  logic signed [31:0] bx_q, by_q, axa_q, aya_q, bxb_q, byb_q;

  // centroids and displacement
  logic signed [SumW-1:0] sax_q, say_q, sbx_q, sby_q;
  logic signed [31:0]     cen_q [4];
  logic signed [31:0]     fx_q, fy_q;
  logic signed [48:0]     ov_q;
  logic [34:0]            ov16_q;
  logic signed [64:0]     pdx_q, pdy_q;
  logic [47:0]            plp_q;
  logic [48:0]            php_q;
  logic signed [31:0]     pushx_q, pushy_q;
  logic                   sat_q;

  // combinational helpers
  logic [CntW-1:0]    np, nside, kmax, ax_nxt, k_nxt, j_idx;
  logic [63:0]        rd_p, rd_s;
  logic signed [31:0] rp_x, rp_y, rs_x, rs_y, ra_x, ra_y, rb_x, rb_y;
  logic signed [32:0] nx, ny;
  logic [32:0]        absx, absy, mmax;
  logic [63:0]        rb;
  logic               sq_ge;
  logic [63:0]        num_x, num_y;
  logic [31:0]        qlo;
  logic signed [63:0] dot;
  logic signed [47:0] dval, lo_n, hi_n;
  logic signed [48:0] o1, o2, ov_cur, best_n;
  logic               take;
  logic signed [31:0] bx_n, by_n;
  logic signed [SumW-1:0] s_sel;
  logic [SumW-1:0]    s_abs;
  logic [CntW-1:0]    den_sel;
  logic signed [31:0] cen_n;
  logic signed [32:0] dx, dy;
  logic signed [65:0] dsum;
  logic [48:0]        ov_rnd;
  logic signed [31:0] f_sel;
  logic [31:0]        f_abs;
  logic [30:0]        mag;
  logic [65:0]        full, rsum;
  logic [35:0]        rr;
  logic               sat_c;
  logic signed [31:0] comp_val;

  assign np     = pass_q ? nb_q : na_q;
  assign nside  = (pass_q ^ side_q) ? nb_q : na_q;
  assign kmax   = (na_q > nb_q) ? na_q : nb_q;
  assign ax_nxt = ax_i_q + 1'b1;
  assign k_nxt  = k_q + 1'b1;
  assign j_idx  = (ax_nxt < np) ? ax_nxt : '0;

  assign rd_p = pass_q ? b_rdata_i : a_rdata_i;
  assign rd_s = (pass_q ^ side_q) ? b_rdata_i : a_rdata_i;
  assign rp_x = $signed(rd_p[63:32]);
  assign rp_y = $signed(rd_p[31:0]);
  assign rs_x = $signed(rd_s[63:32]);
  assign rs_y = $signed(rd_s[31:0]);
  assign ra_x = $signed(a_rdata_i[63:32]);
  assign ra_y = $signed(a_rdata_i[31:0]);
  assign rb_x = $signed(b_rdata_i[63:32]);
  assign rb_y = $signed(b_rdata_i[31:0]);

  // edge normal
  assign nx   = {yi_q[31], yi_q} - {rp_y[31], rp_y};
  assign ny   = {rp_x[31], rp_x} - {xi_q[31], xi_q};
  assign absx = nx[32] ? 33'(-nx) : 33'(nx);
  assign absy = ny[32] ? 33'(-ny) : 33'(ny);
  assign mmax = (mx_q > my_q) ? mx_q : my_q;

  // integer square root step
  assign rb    = r_q + bit_q;
  assign sq_ge = x_q >= rb;

  assign num_x = ({33'd0, mx_q[30:0]} << 30) + {33'd0, r_q[31:1]};
  assign num_y = ({33'd0, my_q[30:0]} << 30) + {33'd0, r_q[31:1]};
  assign qlo   = div_rsp_i.quot[31:0];

  // projection
  assign dot  = prodx_q + prody_q;
  assign dval = dot[63:16];
  assign lo_n = ((k_q == '0) || (dval < lo_q)) ? dval : lo_q;
  assign hi_n = ((k_q == '0) || (dval > hi_q)) ? dval : hi_q;

  // overlap on the current axis
  assign o1     = {hi_q[47], hi_q} - {plo_q[47], plo_q};
  assign o2     = {phi_q[47], phi_q} - {lo_q[47], lo_q};
  assign ov_cur = (o1 < o2) ? o1 : o2;
  assign take   = (ax_i_q == '0) || (ov_cur < best_q);
  assign best_n = take ? ov_cur : best_q;
  assign bx_n   = take ? ux_q : bx_q;
  assign by_n   = take ? uy_q : by_q;

  // centroid division operands
  always_comb begin
    unique case (cd_q)
      2'd0:    s_sel = sax_q;
      2'd1:    s_sel = say_q;
      2'd2:    s_sel = sbx_q;
      default: s_sel = sby_q;
    endcase
  end
  assign s_abs   = s_sel[SumW-1] ? SumW'(-s_sel) : SumW'(s_sel);
  assign den_sel = cd_q[1] ? nb_q : na_q;
  assign cen_n   = s_sel[SumW-1] ? 32'(-$signed(qlo)) : $signed(qlo);

  // centroid offset against displacement
  assign dx     = {cen_q[2][31], cen_q[2]} - {cen_q[0][31], cen_q[0]};
  assign dy     = {cen_q[3][31], cen_q[3]} - {cen_q[1][31], cen_q[1]};
  assign dsum   = {pdx_q[64], pdx_q} + {pdy_q[64], pdy_q};
  assign ov_rnd = {1'b0, ov_q[47:0]} + 49'd8192;

  // push component in two partial products
  assign f_sel = comp_q ? fy_q : fx_q;
  assign f_abs = f_sel[31] ? 32'(-f_sel) : f_sel;
  assign mag   = f_abs[30:0];
  assign full  = {18'd0, plp_q} + {php_q, 17'd0};
  assign rsum  = full + 66'd536870912;
  assign rr    = rsum[65:30];

  always_comb begin
    if (f_sel[31]) begin
      sat_c    = rr > 36'h080000000;
      comp_val = sat_c ? 32'sh80000000 : $signed(~rr[31:0] + 32'd1);
    end else begin
      sat_c    = rr[35:31] != 5'd0;
      comp_val = sat_c ? 32'sh7FFFFFFF : $signed(rr[31:0]);
    end
  end

  // next state and outputs
  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    raddr_o   = k_q[AddrW-1:0];
    div_req_o = '{start: 1'b0, num: num_x, den: r_q[31:0]};
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = ((job_na_i == '0) || (job_nb_i == '0)) ? BK_EMIT_MISS : BK_AX_START;
        end
      end
      BK_AX_START: begin
        state_d = (np == CntW'(1)) ? BK_PJ_RD : BK_AX_RD1;
      end
      BK_AX_RD1: begin
        raddr_o = ax_i_q[AddrW-1:0];
        state_d = BK_AX_RD2;
      end
      BK_AX_RD2: begin
        raddr_o = j_idx[AddrW-1:0];
        state_d = BK_AX_CALC;
      end
      BK_AX_CALC: begin
        state_d = ((absx == '0) && (absy == '0)) ? BK_PJ_RD : BK_NORM;
      end
      BK_NORM: begin
        if (mmax[32:31] == 2'd0 && mmax[30]) begin
          state_d = BK_SQ1;
        end
      end
      BK_SQ1:  state_d = BK_SQ2;
      BK_SQ2:  state_d = BK_SQ3;
      BK_SQ3:  state_d = BK_SQRT;
      BK_SQRT: begin
        if (bit_q[0]) begin
          state_d = BK_DIVX_GO;
        end
      end
      BK_DIVX_GO: begin
        div_req_o.start = 1'b1;
        state_d         = BK_DIVX_WAIT;
      end
      BK_DIVX_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = BK_DIVY_GO;
        end
      end
      BK_DIVY_GO: begin
        div_req_o = '{start: 1'b1, num: num_y, den: r_q[31:0]};
        state_d   = BK_DIVY_WAIT;
      end
      BK_DIVY_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = BK_PJ_RD;
        end
      end
      BK_PJ_RD: state_d = BK_PJ_MX;
      BK_PJ_MX: state_d = BK_PJ_MY;
      BK_PJ_MY: state_d = BK_PJ_AC;
      BK_PJ_AC: begin
        state_d = (k_nxt == nside && side_q) ? BK_OV : BK_PJ_RD;
      end
      BK_OV: begin
        priority if (ov_cur < 0) begin
          state_d = BK_EMIT_MISS;
        end else if (ax_nxt == np && pass_q) begin
          state_d = BK_CS_RD;
        end else begin
          state_d = BK_AX_START;
        end
      end
      BK_CS_RD: state_d = BK_CS_AC;
      BK_CS_AC: begin
        state_d = (k_nxt == kmax) ? BK_CD_GO : BK_CS_RD;
      end
      BK_CD_GO: begin
        div_req_o = '{start: 1'b1, num: DivNumW'(s_abs), den: DivDenW'(den_sel)};
        state_d   = BK_CD_WAIT;
      end
      BK_CD_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = (cd_q == 2'd3) ? BK_CHOOSE : BK_CD_GO;
        end
      end
      BK_CHOOSE: state_d = BK_DOT1;
      BK_DOT1:   state_d = BK_DOT2;
      BK_DOT2:   state_d = BK_DOT3;
      BK_DOT3:   state_d = BK_PU_LO;
      BK_PU_LO:  state_d = BK_PU_HI;
      BK_PU_HI:  state_d = BK_PU_FIN;
      BK_PU_FIN: state_d = comp_q ? BK_EMIT_HIT : BK_PU_LO;
      BK_EMIT_HIT:  state_d = BK_IDLE;
      BK_EMIT_MISS: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == BK_EMIT_HIT) || (state_q == BK_EMIT_MISS);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        na_q   <= job_na_i;
        nb_q   <= job_nb_i;
        pass_q <= 1'b0;
        ax_i_q <= '0;
      end
      BK_AX_START: begin
        ux_q   <= 32'sd1073741824;
        uy_q   <= '0;
        k_q    <= '0;
        side_q <= 1'b0;
      end
      BK_AX_RD1: ;
      BK_AX_RD2: begin
        xi_q <= rp_x;
        yi_q <= rp_y;
      end
      BK_AX_CALC: begin
        nxneg_q <= nx[32];
        nyneg_q <= ny[32];
        mx_q    <= absx;
        my_q    <= absy;
      end
      BK_NORM: begin
        priority if (mmax[32:31] != 2'd0) begin
          mx_q <= mx_q >> 1;
          my_q <= my_q >> 1;
        end else if (!mmax[30]) begin
          mx_q <= mx_q << 1;
          my_q <= my_q << 1;
        end else begin
          mx_q <= mx_q;
        end
      end
      BK_SQ1: sq1_q <= mx_q[30:0] * mx_q[30:0];
      BK_SQ2: sq2_q <= my_q[30:0] * my_q[30:0];
      BK_SQ3: begin
        x_q   <= {2'd0, sq1_q} + {2'd0, sq2_q};
        r_q   <= '0;
        bit_q <= 64'd1 << 62;
      end
      BK_SQRT: begin
        if (sq_ge) begin
          x_q <= x_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      BK_DIVX_GO: ;
      BK_DIVX_WAIT: begin
        if (div_rsp_i.done) begin
          ux_q <= nxneg_q ? 32'(-$signed(qlo)) : $signed(qlo);
        end
      end
      BK_DIVY_GO: ;
      BK_DIVY_WAIT: begin
        if (div_rsp_i.done) begin
          uy_q <= nyneg_q ? 32'(-$signed(qlo)) : $signed(qlo);
        end
      end
      BK_PJ_RD: ;
      BK_PJ_MX: begin
        prodx_q <= rs_x * ux_q;
        yl_q    <= rs_y;
      end
      BK_PJ_MY: prody_q <= yl_q * uy_q;
      BK_PJ_AC: begin
        lo_q <= lo_n;
        hi_q <= hi_n;
        if (k_nxt == nside) begin
          k_q <= '0;
          if (!side_q) begin
            plo_q  <= lo_n;
            phi_q  <= hi_n;
            side_q <= 1'b1;
          end
        end else begin
          k_q <= k_nxt;
        end
      end
      BK_OV: begin
        best_q <= best_n;
        bx_q   <= bx_n;
        by_q   <= by_n;
        if (ax_nxt == np) begin
          ax_i_q <= '0;
          pass_q <= 1'b1;
          k_q    <= '0;
          sax_q  <= '0;
          say_q  <= '0;
          sbx_q  <= '0;
          sby_q  <= '0;
          if (pass_q) begin
            ob_q  <= best_n;
            bxb_q <= bx_n;
            byb_q <= by_n;
          end else begin
            oa_q  <= best_n;
            axa_q <= bx_n;
            aya_q <= by_n;
          end
        end else begin
          ax_i_q <= ax_nxt;
        end
      end
      BK_CS_RD: cd_q <= 2'd0;
      BK_CS_AC: begin
        if (k_q < na_q) begin
          sax_q <= sax_q + SumW'(ra_x);
          say_q <= say_q + SumW'(ra_y);
        end
        if (k_q < nb_q) begin
          sbx_q <= sbx_q + SumW'(rb_x);
          sby_q <= sby_q + SumW'(rb_y);
        end
        k_q <= k_nxt;
      end
      BK_CD_GO: ;
      BK_CD_WAIT: begin
        if (div_rsp_i.done) begin
          cen_q[cd_q] <= cen_n;
          cd_q        <= cd_q + 2'd1;
        end
      end
      BK_CHOOSE: begin
        sat_q <= 1'b0;
        if (oa_q < ob_q) begin
          ov_q <= oa_q;
          fx_q <= axa_q;
          fy_q <= aya_q;
        end else begin
          ov_q <= ob_q;
          fx_q <= 32'(-bxb_q);
          fy_q <= 32'(-byb_q);
        end
      end
      BK_DOT1: pdx_q <= dx * fx_q;
      BK_DOT2: pdy_q <= dy * fy_q;
      BK_DOT3: begin
        if (!dsum[65]) begin
          fx_q <= 32'(-fx_q);
          fy_q <= 32'(-fy_q);
        end
        ov16_q <= ov_rnd[48:14];
        comp_q <= 1'b0;
      end
      BK_PU_LO: plp_q <= mag * ov16_q[16:0];
      BK_PU_HI: php_q <= mag * ov16_q[34:17];
      BK_PU_FIN: begin
        if (comp_q) begin
          pushy_q <= comp_val;
        end else begin
          pushx_q <= comp_val;
        end
        sat_q  <= sat_q | sat_c;
        comp_q <= 1'b1;
      end
      BK_EMIT_HIT: begin
        res_q <= '{hit: 1'b1, push_x: pushx_q, push_y: pushy_q, saturated: sat_q};
      end
      BK_EMIT_MISS: begin
        res_q <= '{hit: 1'b0, push_x: '0, push_y: '0, saturated: 1'b0};
      end
      default: ;
    endcase
  end

  assign busy_o = state_q != BK_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hw/rtl/polygon_sat_collision_core.sv
// vertex beats are accepted while busy is low and written to their store; a finish beat holds busy for the whole test:
// per axis the edge normal is normalized, its length taken by square root, both parts divided by it,
// and both polygons projected; then come the centroid sums, four centroid divisions and the push.
// the result shows on done_o for one cycle and the receiver cannot stall it.
// rst_ni clears counts, job queue and sequencers; vertex stores are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module polygon_sat_collision_core #(
  parameter int unsigned MAX_VERTICES = pscol_pkg::MaxVertices
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  pscol_pkg::in_t  in_i,
  output logic            busy,
  output logic            done_o,
  output pscol_pkg::res_t res_o
);
  import pscol_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic             back_busy;
  logic             we_a, we_b;
  logic [AddrW-1:0] waddr, raddr;
  logic [63:0]      wdata, a_rdata, b_rdata;
  logic             job_valid, job_pop;
  logic [CntW-1:0]  job_na, job_nb;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             miss_clean;

  pscol_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .in_i        (in_i),
    .busy        (busy),
    .back_busy_i (back_busy),
    .we_a_o      (we_a),
    .we_b_o      (we_b),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .job_valid_o (job_valid),
    .job_na_o    (job_na),
    .job_nb_o    (job_nb),
    .job_pop_i   (job_pop)
  );

  pscol_ram #(.Width(64), .Depth(MAX_VERTICES)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (a_rdata)
  );

  pscol_ram #(.Width(64), .Depth(MAX_VERTICES)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (b_rdata)
  );

  pscol_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pscol_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_na_i    (job_na),
    .job_nb_i    (job_nb),
    .job_pop_o   (job_pop),
    .a_rdata_i   (a_rdata),
    .b_rdata_i   (b_rdata),
    .raddr_o     (raddr),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .busy_o      (back_busy),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  // a miss carries no push
  assign miss_clean = (res_o.push_x == '0) && (res_o.push_y == '0) && !res_o.saturated;

  `ASSERT_NEXT(a_single_done, clk_i, rst_ni, done_o, !done_o, "result beat repeated")
  `ASSERT_NEXT(a_finish_busy, clk_i, rst_ni, start && !busy && in_i.finish, busy, "no lock")
  `ASSERT_CLK(a_miss_zero, clk_i, rst_ni, !(done_o && !res_o.hit) || miss_clean, "miss push")

endmodule
